@@ hdl/ltaf_pkg.sv @@
// Package for the leak trend alert filter: shared types and constants.
// No dependencies.
`default_nettype none
package ltaf_pkg;
  localparam int WinMax = 64;
  localparam int SlotW = 6;
  localparam int CntW = 7;

  localparam logic [1:0] CmdDet = 2'd0;
  localparam logic [1:0] CmdEof = 2'd1;
  localparam logic [1:0] CmdClr = 2'd2;

  localparam logic [2:0] RsnNone = 3'd0;
  localparam logic [2:0] RsnCand = 3'd1;
  localparam logic [2:0] RsnRise = 3'd2;
  localparam logic [2:0] RsnDown = 3'd3;
  localparam logic [2:0] RsnConf = 3'd4;
  localparam logic [2:0] RsnFew = 3'd5;

  // Work handed from the front part to the back part.
  typedef struct packed {
    logic        clr;
    logic [9:0]  cnt;
    logic [31:0] area;
    logic [55:0] wsum;
    logic [15:0] peak;
  } job_t;

  typedef struct packed {
    logic        level;
    logic [9:0]  det_count;
    logic [6:0]  hit_frames;
    logic [31:0] frame_area;
    logic [15:0] weighted_row;
    logic [15:0] peak_score;
    logic        window_full;
    logic        area_rising;
    logic        moving_down;
    logic [2:0]  reason_code;
  } res_t;
endpackage
`default_nettype wire

@@ hdl/ltaf_front.sv @@
// Front part: accumulates detections of a frame and queues frame jobs.
// Depends on ltaf_pkg.
`default_nettype none
module ltaf_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  output logic               ready_o,
  input  wire logic [1:0]    cmd_i,
  input  wire logic [23:0]   area_i,
  input  wire logic [15:0]   row_pos_i,
  input  wire logic [15:0]   score_i,
  output logic               job_valid_o,
  input  wire logic          job_ready_i,
  output ltaf_pkg::job_t     job_o
);
  logic [31:0] sa_q, sa_d;
  logic [55:0] sw_q, sw_d;
  logic [9:0]  ic_q, ic_d;
  logic [15:0] ms_q, ms_d;
  // Two-entry queue of jobs.
  ltaf_pkg::job_t qm_q [2];
  logic [1:0] qn_q, qn_d;
  logic       rp_q, wp_q;
  logic [39:0] prod;
  logic [32:0] s;
  logic [56:0] w;
  logic acc, push, pop;
  ltaf_pkg::job_t nj;

  assign ready_o = (qn_q != 2'd2);
  assign acc = valid_i && ready_o;
  assign push = acc && (cmd_i == ltaf_pkg::CmdEof || cmd_i == ltaf_pkg::CmdClr);
  assign pop = job_valid_o && job_ready_i;
  assign job_valid_o = (qn_q != 2'd0);
  assign job_o = qm_q[rp_q];

  always_comb begin
    prod = {16'd0, area_i} * {24'd0, row_pos_i};
    s = {1'b0, sa_q} + {9'd0, area_i};
    w = {1'b0, sw_q} + {17'd0, prod};
    sa_d = sa_q; sw_d = sw_q; ic_d = ic_q; ms_d = ms_q;
    nj.clr = (cmd_i == ltaf_pkg::CmdClr);
    nj.cnt = ic_q; nj.area = sa_q; nj.wsum = sw_q; nj.peak = ms_q;
    if (acc && cmd_i == ltaf_pkg::CmdDet) begin
      sa_d = s[32] ? 32'hFFFF_FFFF : s[31:0];
      sw_d = w[56] ? {56{1'b1}} : w[55:0];
      if (ic_q != 10'd1023) ic_d = ic_q + 10'd1;
      if (score_i > ms_q) ms_d = score_i;
    end else if (acc && cmd_i == ltaf_pkg::CmdEof) begin
      sa_d = '0; sw_d = '0; ic_d = '0; ms_d = '0;
    end
    qn_d = qn_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_q <= '0; sw_q <= '0; ic_q <= '0; ms_q <= '0;
      qn_q <= '0; rp_q <= 1'b0; wp_q <= 1'b0;
    end else begin
      sa_q <= sa_d; sw_q <= sw_d; ic_q <= ic_d; ms_q <= ms_d;
      qn_q <= qn_d;
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) qm_q[wp_q] <= nj;
  end
endmodule
`default_nettype wire

@@ hdl/ltaf_back.sv @@
// Back part: divides for the centroid, updates the history ring, tests trends.
// Depends on ltaf_pkg.
`default_nettype none
module ltaf_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          job_valid_i,
  output logic               job_ready_o,
  input  wire ltaf_pkg::job_t job_i,
  input  wire logic [6:0]    window_length_i,
  input  wire logic [6:0]    min_hit_frames_i,
  input  wire logic [15:0]   growth_ratio_i,
  input  wire logic [15:0]   down_offset_i,
  output logic               res_valid_o,
  input  wire logic          res_ready_i,
  output ltaf_pkg::res_t     res_o
);
  typedef enum logic [6:0] {
    SIdle = 7'b0000001, SDiv = 7'b0000010, STrim = 7'b0000100,
    SWrite = 7'b0001000, SRdOld = 7'b0010000, SCmp = 7'b0100000,
    SOut = 7'b1000000
  } state_e;
  state_e st_q, st_d;

  logic [31:0] area_mem [ltaf_pkg::WinMax];
  logic [15:0] row_mem [ltaf_pkg::WinMax];
  logic        hit_mem [ltaf_pkg::WinMax];

  ltaf_pkg::job_t jb_q;
  logic [55:0] rem_q;
  logic [55:0] quo_q;
  logic [5:0]  dc_q;
  logic [ltaf_pkg::SlotW-1:0] ws_q;
  logic [ltaf_pkg::CntW-1:0]  fl_q, ht_q;
  logic [6:0]  win;
  logic [15:0] cen_q;
  logic [ltaf_pkg::SlotW-1:0] ra;
  logic [31:0] ard_q;
  logic [15:0] rrd_q;
  logic        hrd_q;
  logic        trim_pend_q;
  logic [47:0] lhs, rhs;
  logic [16:0] rsum;
  logic        rise, down;
  logic [56:0] trial;
  ltaf_pkg::res_t res_q;
  logic [15:0] newest_row_q;
  logic [31:0] newest_area_q;

  always_comb begin
    win = window_length_i;
    if (win == 7'd0) win = 7'd1;
    if (win > 7'(ltaf_pkg::WinMax)) win = 7'(ltaf_pkg::WinMax);
    // Oldest entry is fl entries behind the write slot.
    ra = ws_q - fl_q[ltaf_pkg::SlotW-1:0];
    trial = {rem_q, quo_q[55]} - {25'd0, jb_q.area};
    lhs = {8'd0, newest_area_q, 8'd0};
    rhs = 48'(ard_q) * 48'(growth_ratio_i);
    rsum = {1'b0, rrd_q} + {1'b0, down_offset_i};
    rise = (lhs > rhs);
    down = ({1'b0, newest_row_q} > rsum);
  end

  assign job_ready_o = (st_q == SIdle);
  assign res_valid_o = (st_q == SOut);
  assign res_o = res_q;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      SIdle:  if (job_valid_i) st_d = job_i.clr ? SIdle : SDiv;
      SDiv:   if (dc_q == 6'd55) st_d = STrim;
      STrim:  if (fl_q < win && !trim_pend_q) st_d = SWrite;
      SWrite: st_d = SRdOld;
      SRdOld: st_d = SCmp;
      SCmp:   st_d = SOut;
      SOut:   if (res_ready_i) st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; ws_q <= '0; fl_q <= '0; ht_q <= '0; trim_pend_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == SIdle && job_valid_i && job_i.clr) begin
        ws_q <= '0; fl_q <= '0; ht_q <= '0;
      end
      if (st_q == STrim) begin
        // A dropped entry's hit comes from a registered read at its address.
        if (trim_pend_q) begin
          ht_q <= ht_q - {6'd0, hrd_q};
          fl_q <= fl_q - 7'd1;
          trim_pend_q <= 1'b0;
        end else if (fl_q >= win) begin
          trim_pend_q <= 1'b1;
        end
      end
      if (st_q == SWrite) begin
        ws_q <= ws_q + 6'd1;
        fl_q <= fl_q + 7'd1;
        ht_q <= ht_q + {6'd0, (jb_q.cnt != 10'd0)};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ard_q <= area_mem[ra];
    rrd_q <= row_mem[ra];
    hrd_q <= hit_mem[ra];
    if (st_q == SWrite) begin
      area_mem[ws_q] <= jb_q.area;
      row_mem[ws_q] <= cen_q;
      hit_mem[ws_q] <= (jb_q.cnt != 10'd0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == SIdle && job_valid_i) begin
      jb_q <= job_i;
      rem_q <= '0;
      quo_q <= job_i.wsum;
      dc_q <= '0;
    end
    if (st_q == SDiv) begin
      // Restoring division, one quotient bit a cycle.
      dc_q <= dc_q + 6'd1;
      if (!trial[56]) begin
        rem_q <= trial[55:0];
        quo_q <= {quo_q[54:0], 1'b1};
      end else begin
        rem_q <= {rem_q[54:0], quo_q[55]};
        quo_q <= {quo_q[54:0], 1'b0};
      end
    end
    if (st_q == STrim) begin
      if (jb_q.area == 32'd0) cen_q <= '0;
      else if (quo_q[55:16] != 40'd0) cen_q <= 16'hFFFF;
      else cen_q <= quo_q[15:0];
    end
    if (st_q == SWrite) begin
      newest_area_q <= jb_q.area;
      newest_row_q <= cen_q;
    end
    if (st_q == SCmp) begin
      res_q.level <= 1'b0;
      res_q.det_count <= jb_q.cnt;
      res_q.hit_frames <= ht_q;
      res_q.frame_area <= jb_q.area;
      res_q.weighted_row <= cen_q;
      res_q.peak_score <= jb_q.peak;
      res_q.window_full <= (fl_q >= win);
      res_q.area_rising <= 1'b0;
      res_q.moving_down <= 1'b0;
      res_q.reason_code <= (jb_q.cnt != 10'd0) ? ltaf_pkg::RsnCand : ltaf_pkg::RsnNone;
      if (fl_q >= win) begin
        res_q.area_rising <= rise;
        res_q.moving_down <= down;
        if (ht_q >= min_hit_frames_i) begin
          if (rise) begin
            res_q.level <= 1'b1; res_q.reason_code <= ltaf_pkg::RsnRise;
          end else if (down) begin
            res_q.level <= 1'b1; res_q.reason_code <= ltaf_pkg::RsnDown;
          end else begin
            res_q.reason_code <= ltaf_pkg::RsnConf;
          end
        end else begin
          res_q.reason_code <= ltaf_pkg::RsnFew;
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ hdl/leak_trend_alert_filter.sv @@
// Top level of the leak trend alert filter.
// Depends on ltaf_pkg, ltaf_front and ltaf_back.
//
// Input channel (valid_i and ready_o) takes one item per cycle while
// ready_o is high: cmd 0 is a detection, cmd 1 ends a frame, cmd 2 clears
// the history and cmd 3 is ignored. Detections are accumulated in the
// front part at one per cycle while ready_o is high, with no result. An
// end of frame or a clear is queued (two entries) for the back part, so
// detections of the next frame keep flowing. The back part runs a
// bit-serial division for the centroid, drops the oldest history entries
// while the ring holds the window length or more, writes the ring, reads
// the oldest entry and tests the trends. A clear is taken in the idle
// state of the back part. Each frame holds the back part until its result
// is taken, so frames that come faster wait in the queue. The result sits
// in an output register until the receiver takes it; while it waits the
// queue fills and then ready_o falls.
// Reset empties the history and the frame sums and loads the register
// defaults; ring contents are undefined until written.
`default_nettype none
module leak_trend_alert_filter (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             ready_o,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [23:0] area_i,
  input  wire logic [15:0] row_pos_i,
  input  wire logic [15:0] score_i,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  output logic             valid_o,
  input  wire logic        ready_i,
  output logic             level_o,
  output logic [9:0]       det_count_o,
  output logic [6:0]       hit_frames_o,
  output logic [31:0]      frame_area_o,
  output logic [15:0]      weighted_row_o,
  output logic [15:0]      peak_score_o,
  output logic             window_full_o,
  output logic             area_rising_o,
  output logic             moving_down_o,
  output logic [2:0]       reason_code_o
);
  logic [6:0]  wl_q, mh_q;
  logic [15:0] gr_q, do_q;
  logic jv, jr;
  ltaf_pkg::job_t job;
  ltaf_pkg::res_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q <= 7'd8; mh_q <= 7'd4; gr_q <= 16'd307; do_q <= 16'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        2'd0: wl_q <= cfg_data_i[6:0];
        2'd1: mh_q <= cfg_data_i[6:0];
        2'd2: gr_q <= cfg_data_i;
        2'd3: do_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ltaf_front u_front (
    .clk_i, .rst_ni, .valid_i, .ready_o, .cmd_i, .area_i, .row_pos_i, .score_i,
    .job_valid_o(jv), .job_ready_i(jr), .job_o(job)
  );

  ltaf_back u_back (
    .clk_i, .rst_ni, .job_valid_i(jv), .job_ready_o(jr), .job_i(job),
    .window_length_i(wl_q), .min_hit_frames_i(mh_q),
    .growth_ratio_i(gr_q), .down_offset_i(do_q),
    .res_valid_o(valid_o), .res_ready_i(ready_i), .res_o(res)
  );

  assign level_o = res.level;
  assign det_count_o = res.det_count;
  assign hit_frames_o = res.hit_frames;
  assign frame_area_o = res.frame_area;
  assign weighted_row_o = res.weighted_row;
  assign peak_score_o = res.peak_score;
  assign window_full_o = res.window_full;
  assign area_rising_o = res.area_rising;
  assign moving_down_o = res.moving_down;
  assign reason_code_o = res.reason_code;
endmodule
`default_nettype wire
